>>> design/assert_macros.svh
// Assertion macros shared by the checking code of the number scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/jns_pkg.sv
// Types and constants shared by the number scanner modules.
package jns_pkg;

  localparam int CHAR_W     = 8;
  localparam int MANT_W     = 64;
  localparam int EXP_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int OUT_DATA_W = 112;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character classes produced by the front
  typedef enum logic [3:0] {
    CL_END,
    CL_WS,
    CL_N,
    CL_U,
    CL_L,
    CL_MINUS,
    CL_PLUS,
    CL_ZERO,
    CL_DIGIT,
    CL_DOT,
    CL_EXP,
    CL_OTHER
  } cls_e;

  typedef enum logic [3:0] {
    PH_WS,
    PH_NULL_OK,
    PH_NULL_BAD,
    PH_SIGN,
    PH_ZEROS,
    PH_INT,
    PH_FRAC,
    PH_EXP_START,
    PH_EXP_SIGN,
    PH_EXP_DIG
  } phase_e;

  // Work the back end does on one character
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INT_DIGIT,
    ACT_FRAC_DIGIT,
    ACT_EXP_DIGIT,
    ACT_MINUS,
    ACT_EXP_NEG,
    ACT_DOT,
    ACT_NULL_STEP,
    ACT_EMIT_NUM,
    ACT_EMIT_NULL,
    ACT_EMIT_ERR,
    ACT_CLEAR
  } act_e;

  typedef enum logic [1:0] {
    KIND_UNSIGNED,
    KIND_SIGNED,
    KIND_FLOAT,
    KIND_NULL
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_NO_DIGIT,
    ERR_END,
    ERR_NULL
  } err_e;

  typedef struct packed {
    cls_e              cls;
    logic [CHAR_W-1:0] ch;
  } q_entry_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    kind_e             kind;
    logic              is_negative;
    logic [MANT_W-1:0] mantissa;
    logic [EXP_W-1:0]  decimal_exponent;
    err_e              error_code;
    logic [CHAR_W-1:0] terminator;
    logic              ended_by_end_mark;
  } res_t;

endpackage

>>> design/jns_front.sv
// Front end: input handshake and character classification.
module jns_front (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [7:0]         s_tdata_i,
  input  logic               s_tuser_i,
  input  jns_pkg::q_stat_t   stat_i,
  output logic               push_o,
  output jns_pkg::q_entry_t  entry_o
);

  localparam logic [7:0] WS_MAX   = 8'd32;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  jns_pkg::cls_e cls;

  // Classify the incoming byte; the end mark wins over any character
  always_comb begin
    if (s_tuser_i) begin
      cls = jns_pkg::CL_END;
    end else if (s_tdata_i <= WS_MAX || s_tdata_i[7]) begin
      cls = jns_pkg::CL_WS;
    end else if (s_tdata_i == CH_N) begin
      cls = jns_pkg::CL_N;
    end else if (s_tdata_i == CH_U) begin
      cls = jns_pkg::CL_U;
    end else if (s_tdata_i == CH_L) begin
      cls = jns_pkg::CL_L;
    end else if (s_tdata_i == CH_MINUS) begin
      cls = jns_pkg::CL_MINUS;
    end else if (s_tdata_i == CH_PLUS) begin
      cls = jns_pkg::CL_PLUS;
    end else if (s_tdata_i == CH_0) begin
      cls = jns_pkg::CL_ZERO;
    end else if (s_tdata_i >= CH_1 && s_tdata_i <= CH_9) begin
      cls = jns_pkg::CL_DIGIT;
    end else if (s_tdata_i == CH_DOT) begin
      cls = jns_pkg::CL_DOT;
    end else if (s_tdata_i == CH_E_LO || s_tdata_i == CH_E_UP) begin
      cls = jns_pkg::CL_EXP;
    end else begin
      cls = jns_pkg::CL_OTHER;
    end
  end

  // Accept whenever the queue has room
  assign s_tready_o  = !stat_i.full;
  assign push_o      = s_tvalid_i && !stat_i.full;
  assign entry_o.cls = cls;
  assign entry_o.ch  = s_tdata_i;

endmodule

>>> design/jns_fifo.sv
// Short queue of classified characters between front and back.
module jns_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jns_pkg::q_entry_t  entry_i,
  input  logic               pop_i,
  output jns_pkg::q_entry_t  entry_o,
  output jns_pkg::q_stat_t   stat_o
);

  localparam logic [jns_pkg::QPTR_W-1:0] PTR_LAST = jns_pkg::QPTR_W'(jns_pkg::QDEPTH - 1);
  localparam logic [jns_pkg::QCNT_W-1:0] CNT_FULL = jns_pkg::QCNT_W'(jns_pkg::QDEPTH);

  jns_pkg::q_entry_t             mem_q [jns_pkg::QDEPTH];
  logic [jns_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [jns_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [jns_pkg::QCNT_W-1:0]    count_q, count_d;

  // Storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == CNT_FULL);
  assign stat_o.count = count_q;

endmodule

>>> design/jns_back.sv
// Back end: token state machine, digit accumulators and result register.
module jns_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  jns_pkg::q_entry_t  entry_i,
  output logic               pop_o,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output jns_pkg::res_t      res_o
);

  jns_pkg::phase_e                 phase_q, phase_d;
  jns_pkg::act_e                   act;
  jns_pkg::err_e                   err_sel;
  logic [jns_pkg::MANT_W-1:0]      mant_q, mant_d;
  logic [jns_pkg::FRAC_W-1:0]      frac_q, frac_d;
  logic [jns_pkg::EXP_W-1:0]       exp_q, exp_d;
  logic                            expneg_q, expneg_d;
  logic                            minus_q, minus_d;
  logic                            dot_q, dot_d;
  logic [1:0]                      null_idx_q, null_idx_d;
  logic                            out_valid_q;
  jns_pkg::res_t                   res_q, res;
  logic                            emit;
  logic                            clear_all;
  logic                            is_dig;
  logic                            null_bad;
  jns_pkg::cls_e                   null_want;
  logic [3:0]                      digit;
  logic [jns_pkg::FRAC_W-1:0]      neg_cnt;
  logic [jns_pkg::EXP_W-1:0]       scale;

  // Take a character when the result register is free or being drained
  assign pop_o  = q_valid_i && (!out_valid_q || res_ready_i);
  assign is_dig = (entry_i.cls == jns_pkg::CL_ZERO) || (entry_i.cls == jns_pkg::CL_DIGIT);
  assign digit  = entry_i.ch[3:0];

  // Null tail expects 'u' then 'l' twice; a bad letter sticks until the fourth char
  assign null_want = (null_idx_q == 2'd0) ? jns_pkg::CL_U : jns_pkg::CL_L;
  assign null_bad  = (entry_i.cls != null_want) || (phase_q == jns_pkg::PH_NULL_BAD);

  // Next state and the action for this character
  always_comb begin
    phase_d = phase_q;
    act     = jns_pkg::ACT_NONE;
    err_sel = jns_pkg::ERR_OK;
    if (pop_o) begin
      if (entry_i.cls == jns_pkg::CL_END) begin
        case (phase_q)
          jns_pkg::PH_ZEROS, jns_pkg::PH_INT, jns_pkg::PH_FRAC, jns_pkg::PH_EXP_DIG: begin
            act = jns_pkg::ACT_EMIT_NUM;
          end
          default: begin
            act     = jns_pkg::ACT_EMIT_ERR;
            err_sel = jns_pkg::ERR_END;
          end
        endcase
      end else begin
        case (phase_q)
          jns_pkg::PH_WS: begin
            if (entry_i.cls == jns_pkg::CL_WS) begin
              act = jns_pkg::ACT_NONE;
            end else if (entry_i.cls == jns_pkg::CL_N) begin
              phase_d = jns_pkg::PH_NULL_OK;
            end else if (entry_i.cls == jns_pkg::CL_MINUS) begin
              phase_d = jns_pkg::PH_SIGN;
              act     = jns_pkg::ACT_MINUS;
            end else if (entry_i.cls == jns_pkg::CL_ZERO) begin
              phase_d = jns_pkg::PH_ZEROS;
            end else if (entry_i.cls == jns_pkg::CL_DIGIT) begin
              phase_d = jns_pkg::PH_INT;
              act     = jns_pkg::ACT_INT_DIGIT;
            end else begin
              act     = jns_pkg::ACT_EMIT_ERR;
              err_sel = jns_pkg::ERR_NO_DIGIT;
            end
          end
          jns_pkg::PH_NULL_OK, jns_pkg::PH_NULL_BAD: begin
            if (null_idx_q[1]) begin
              if (null_bad) begin
                act     = jns_pkg::ACT_EMIT_ERR;
                err_sel = jns_pkg::ERR_NULL;
              end else begin
                act = jns_pkg::ACT_EMIT_NULL;
              end
            end else begin
              phase_d = null_bad ? jns_pkg::PH_NULL_BAD : jns_pkg::PH_NULL_OK;
              act     = jns_pkg::ACT_NULL_STEP;
            end
          end
          jns_pkg::PH_SIGN: begin
            if (entry_i.cls == jns_pkg::CL_ZERO) begin
              phase_d = jns_pkg::PH_ZEROS;
            end else if (entry_i.cls == jns_pkg::CL_DIGIT) begin
              phase_d = jns_pkg::PH_INT;
              act     = jns_pkg::ACT_INT_DIGIT;
            end else begin
              act     = jns_pkg::ACT_EMIT_ERR;
              err_sel = jns_pkg::ERR_NO_DIGIT;
            end
          end
          jns_pkg::PH_ZEROS, jns_pkg::PH_INT: begin
            if (entry_i.cls == jns_pkg::CL_ZERO && phase_q == jns_pkg::PH_ZEROS) begin
              act = jns_pkg::ACT_NONE;
            end else if (is_dig) begin
              phase_d = jns_pkg::PH_INT;
              act     = jns_pkg::ACT_INT_DIGIT;
            end else if (entry_i.cls == jns_pkg::CL_DOT) begin
              phase_d = jns_pkg::PH_FRAC;
              act     = jns_pkg::ACT_DOT;
            end else if (entry_i.cls == jns_pkg::CL_EXP) begin
              phase_d = jns_pkg::PH_EXP_START;
            end else begin
              act = jns_pkg::ACT_EMIT_NUM;
            end
          end
          jns_pkg::PH_FRAC: begin
            if (is_dig) begin
              act = jns_pkg::ACT_FRAC_DIGIT;
            end else if (entry_i.cls == jns_pkg::CL_EXP) begin
              phase_d = jns_pkg::PH_EXP_START;
            end else begin
              act = jns_pkg::ACT_EMIT_NUM;
            end
          end
          jns_pkg::PH_EXP_START: begin
            if (entry_i.cls == jns_pkg::CL_PLUS) begin
              phase_d = jns_pkg::PH_EXP_SIGN;
            end else if (entry_i.cls == jns_pkg::CL_MINUS) begin
              phase_d = jns_pkg::PH_EXP_SIGN;
              act     = jns_pkg::ACT_EXP_NEG;
            end else if (is_dig) begin
              phase_d = jns_pkg::PH_EXP_DIG;
              act     = jns_pkg::ACT_EXP_DIGIT;
            end else begin
              act = jns_pkg::ACT_EMIT_NUM;
            end
          end
          jns_pkg::PH_EXP_SIGN, jns_pkg::PH_EXP_DIG: begin
            if (is_dig) begin
              phase_d = jns_pkg::PH_EXP_DIG;
              act     = jns_pkg::ACT_EXP_DIGIT;
            end else begin
              act = jns_pkg::ACT_EMIT_NUM;
            end
          end
          default: begin
            act = jns_pkg::ACT_CLEAR;
          end
        endcase
      end
      if (act == jns_pkg::ACT_EMIT_NUM || act == jns_pkg::ACT_EMIT_NULL ||
          act == jns_pkg::ACT_EMIT_ERR || act == jns_pkg::ACT_CLEAR) begin
        phase_d = jns_pkg::PH_WS;
      end
    end
  end

  // Accumulator updates and result fields
  always_comb begin
    mant_d     = mant_q;
    frac_d     = frac_q;
    exp_d      = exp_q;
    expneg_d   = expneg_q;
    minus_d    = minus_q;
    dot_d      = dot_q;
    null_idx_d = null_idx_q;
    emit       = 1'b0;
    clear_all  = 1'b0;
    res        = '0;
    // scale = sign-extended negative fraction count
    neg_cnt    = -frac_q;
    scale      = {{(jns_pkg::EXP_W - jns_pkg::FRAC_W){neg_cnt[jns_pkg::FRAC_W-1]}}, neg_cnt};
    case (act)
      jns_pkg::ACT_INT_DIGIT: begin
        mant_d = (mant_q << 3) + (mant_q << 1) + jns_pkg::MANT_W'(digit);
      end
      jns_pkg::ACT_FRAC_DIGIT: begin
        mant_d = (mant_q << 3) + (mant_q << 1) + jns_pkg::MANT_W'(digit);
        frac_d = frac_q + 1'b1;
      end
      jns_pkg::ACT_EXP_DIGIT: begin
        exp_d = (exp_q << 3) + (exp_q << 1) + jns_pkg::EXP_W'(digit);
      end
      jns_pkg::ACT_MINUS: begin
        minus_d = 1'b1;
      end
      jns_pkg::ACT_EXP_NEG: begin
        expneg_d = 1'b1;
      end
      jns_pkg::ACT_DOT: begin
        dot_d = 1'b1;
      end
      jns_pkg::ACT_NULL_STEP: begin
        null_idx_d = null_idx_q + 1'b1;
      end
      jns_pkg::ACT_EMIT_NUM: begin
        emit                  = 1'b1;
        clear_all             = 1'b1;
        res.is_negative       = minus_q;
        res.mantissa          = mant_q;
        res.ended_by_end_mark = (entry_i.cls == jns_pkg::CL_END);
        res.terminator        = (entry_i.cls == jns_pkg::CL_END) ? '0 : entry_i.ch;
        if (dot_q) begin
          res.kind             = jns_pkg::KIND_FLOAT;
          res.decimal_exponent = expneg_q ? (scale - exp_q) : (scale + exp_q);
        end else begin
          res.kind = minus_q ? jns_pkg::KIND_SIGNED : jns_pkg::KIND_UNSIGNED;
        end
      end
      jns_pkg::ACT_EMIT_NULL: begin
        emit      = 1'b1;
        clear_all = 1'b1;
        res.kind  = jns_pkg::KIND_NULL;
      end
      jns_pkg::ACT_EMIT_ERR: begin
        emit                  = 1'b1;
        clear_all             = 1'b1;
        res.error_code        = err_sel;
        res.terminator        = (err_sel == jns_pkg::ERR_NO_DIGIT) ? entry_i.ch : '0;
        res.ended_by_end_mark = (err_sel == jns_pkg::ERR_END);
      end
      jns_pkg::ACT_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (clear_all) begin
      mant_d     = '0;
      frac_d     = '0;
      exp_d      = '0;
      expneg_d   = 1'b0;
      minus_d    = 1'b0;
      dot_d      = 1'b0;
      null_idx_d = '0;
    end
  end

  // Token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jns_pkg::PH_WS;
      mant_q     <= '0;
      frac_q     <= '0;
      exp_q      <= '0;
      expneg_q   <= 1'b0;
      minus_q    <= 1'b0;
      dot_q      <= 1'b0;
      null_idx_q <= '0;
    end else begin
      phase_q    <= phase_d;
      mant_q     <= mant_d;
      frac_q     <= frac_d;
      exp_q      <= exp_d;
      expneg_q   <= expneg_d;
      minus_q    <= minus_d;
      dot_q      <= dot_d;
      null_idx_q <= null_idx_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/json_number_scanner_unit.sv
// Top level of the streaming JSON number and null scanner.
//
//  channel  | direction | tdata                           | tuser
//  ---------+-----------+---------------------------------+--------------
//  s_axis   | in        | char_byte                       | end_mark
//  m_axis   | out       | token fields, see port comment  | kind
//
// One character is taken per cycle while the queue has room; a result is
// registered in the cycle after the character that ends the token is taken
// by the back end's token state machine.
// A two-entry queue parts the classifier from the state machine, so input
// keeps flowing for two characters while the result register is stalled.
// Reset is asynchronous, active low, and returns to whitespace skipping.
`include "assert_macros.svh"

module json_number_scanner_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_byte
  input  logic [7:0]                        s_axis_tdata,
  // [0] end_mark
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] is_negative, [64:1] mantissa, [96:65] decimal_exponent,
  // [98:97] error_code, [106:99] terminator, [107] ended_by_end_mark, [111:108] zero
  output logic [jns_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                        m_axis_tuser
);

  logic               q_push;
  logic               q_pop;
  jns_pkg::q_entry_t  q_in;
  jns_pkg::q_entry_t  q_head;
  jns_pkg::q_stat_t   q_stat;
  jns_pkg::res_t      res;

  // Classifier and input handshake
  jns_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .stat_i     (q_stat),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  // Queue between the two halves
  jns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_head),
    .stat_o  (q_stat)
  );

  // Token state machine and result register
  jns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_stat.valid),
    .entry_i     (q_head),
    .pop_o       (q_pop),
    .res_ready_i (m_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res)
  );

  // Output packing
  assign m_axis_tdata = {4'b0000, res.ended_by_end_mark, res.terminator, res.error_code,
                         res.decimal_exponent, res.mantissa, res.is_negative};
  assign m_axis_tuser = res.kind;

  // Checks
  `ASSERT_AT(q_fill_bound, q_stat.count <= jns_pkg::QCNT_W'(jns_pkg::QDEPTH), "queue overfilled")
  `ASSERT_AT(pop_needs_entry, q_pop |-> q_stat.valid, "pop from empty queue")
  `ASSERT_NEXT(end_gives_result, q_pop && (q_head.cls == jns_pkg::CL_END), m_axis_tvalid, "end mark produced no result")
  `ASSERT_AT(err_has_no_kind, (m_axis_tvalid && (res.error_code != jns_pkg::ERR_OK)) |-> (res.kind == jns_pkg::KIND_UNSIGNED), "error result with nonzero kind")

endmodule

>>> test/json_number_scanner_unit_test.sv
// Self-checking testbench for the streaming JSON number and null scanner.
`timescale 1ns / 100ps

module json_number_scanner_unit_test;

  // Characters the scanner treats specially
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_LOW_E = "e";
  localparam logic [7:0] CH_UP_E  = "E";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_COMMA = ",";

  localparam int            ITEMS_PER_STAGE = 550;
  localparam int            QUIET_LIMIT     = 1000;
  localparam int            DRAIN_CYCLES    = 8;
  localparam int            REPORT_MAX      = 10;
  localparam jns_pkg::res_t NO_RES          = '0;

  typedef struct {
    logic [7:0] ch;
    logic       eom;
  } stim_t;

  typedef struct {
    logic [7:0]    ch;
    logic          eom;
    bit            typed;
    jns_pkg::res_t want;
  } row_t;

  logic                           clk_i  = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic [7:0]                     s_tdata  = 8'h00;
  logic                           s_tuser  = 1'b0;
  logic                           m_tready = 1'b0;
  logic                           s_axis_tready;
  logic                           m_axis_tvalid;
  logic [jns_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                     m_axis_tuser;

  json_number_scanner_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Scanner state mirrored by the predictor
  jns_pkg::phase_e scan_ph;
  logic [63:0]     mant_acc;
  logic [7:0]      frac_cnt;
  logic [31:0]     exp_acc;
  logic            exp_neg;
  logic            neg_sign;
  logic            dot_flag;
  logic [1:0]      null_pos;

  jns_pkg::res_t expected_tokens[$];
  stim_t         token_chars[$];
  row_t          dir_rows[$];
  int            items_sent;
  int            fail_count;
  int            quiet_cycles;
  int            src_idle;
  int            sink_idle;
  jns_pkg::res_t seen_tok;
  jns_pkg::res_t want_tok;

  function automatic void scan_clear();
    scan_ph  = jns_pkg::PH_WS;
    mant_acc = '0;
    frac_cnt = '0;
    exp_acc  = '0;
    exp_neg  = 1'b0;
    neg_sign = 1'b0;
    dot_flag = 1'b0;
    null_pos = '0;
  endfunction

  function automatic bit is_dig(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic void add_mant_digit(input logic [7:0] ch);
    mant_acc = mant_acc * 64'd10 + {60'd0, ch[3:0]};
  endfunction

  function automatic void add_exp_digit(input logic [7:0] ch);
    exp_acc = exp_acc * 32'd10 + {28'd0, ch[3:0]};
    scan_ph = jns_pkg::PH_EXP_DIG;
  endfunction

  function automatic jns_pkg::res_t fixed_res(input jns_pkg::kind_e k,
                                              input jns_pkg::err_e e,
                                              input logic [7:0] term,
                                              input logic ended);
    jns_pkg::res_t r;
    r = '0;
    r.kind              = k;
    r.error_code        = e;
    r.terminator        = term;
    r.ended_by_end_mark = ended;
    return r;
  endfunction

  function automatic jns_pkg::res_t error_token(input jns_pkg::err_e e,
                                                input logic [7:0] term,
                                                input logic ended);
    scan_clear();
    return fixed_res(jns_pkg::KIND_UNSIGNED, e, term, ended);
  endfunction

  // Finished number: fraction count negated as a signed byte, then the exponent applied
  function automatic jns_pkg::res_t number_token(input logic [7:0] term, input logic ended);
    jns_pkg::res_t r;
    logic [7:0]    neg8;
    logic [31:0]   scale;
    r = '0;
    if (dot_flag) begin
      neg8  = 8'd0 - frac_cnt;
      scale = {{24{neg8[7]}}, neg8};
      r.decimal_exponent = exp_neg ? scale - exp_acc : scale + exp_acc;
      r.kind = jns_pkg::KIND_FLOAT;
    end else begin
      r.kind = neg_sign ? jns_pkg::KIND_SIGNED : jns_pkg::KIND_UNSIGNED;
    end
    r.is_negative       = neg_sign;
    r.mantissa          = mant_acc;
    r.terminator        = term;
    r.ended_by_end_mark = ended;
    scan_clear();
    return r;
  endfunction

  // First character after whitespace or the minus sign
  function automatic bit start_number(input logic [7:0] ch, output jns_pkg::res_t r);
    r = '0;
    if (ch == CH_ZERO) begin
      scan_ph = jns_pkg::PH_ZEROS;
      return 1'b0;
    end
    if (is_dig(ch)) begin
      add_mant_digit(ch);
      scan_ph = jns_pkg::PH_INT;
      return 1'b0;
    end
    r = error_token(jns_pkg::ERR_NO_DIGIT, ch, 1'b0);
    return 1'b1;
  endfunction

  // One input transaction through the predictor; returns 1 when a token completes
  function automatic bit scan_char(input logic [7:0] ch, input logic eom,
                                   output jns_pkg::res_t r);
    bit         got;
    logic [7:0] tail;
    r   = '0;
    got = 1'b1;
    if (eom) begin
      if (scan_ph inside {jns_pkg::PH_ZEROS, jns_pkg::PH_INT, jns_pkg::PH_FRAC,
                          jns_pkg::PH_EXP_DIG})
        r = number_token(8'h00, 1'b1);
      else
        r = error_token(jns_pkg::ERR_END, 8'h00, 1'b1);
    end else begin
      case (scan_ph)
        jns_pkg::PH_WS: begin
          if (ch <= CH_SPACE || ch[7]) begin
            got = 1'b0;
          end else if (ch == CH_N) begin
            scan_ph  = jns_pkg::PH_NULL_OK;
            null_pos = '0;
            got      = 1'b0;
          end else if (ch == CH_MINUS) begin
            neg_sign = 1'b1;
            scan_ph  = jns_pkg::PH_SIGN;
            got      = 1'b0;
          end else begin
            got = start_number(ch, r);
          end
        end
        jns_pkg::PH_NULL_OK, jns_pkg::PH_NULL_BAD: begin
          // three characters are taken after 'n' unless the end mark comes first, checked as they come
          tail = (null_pos == 2'd0) ? CH_U : CH_L;
          if (ch != tail) scan_ph = jns_pkg::PH_NULL_BAD;
          if (null_pos == 2'd2) begin
            if (scan_ph == jns_pkg::PH_NULL_OK) begin
              r.kind = jns_pkg::KIND_NULL;
              scan_clear();
            end else begin
              r = error_token(jns_pkg::ERR_NULL, 8'h00, 1'b0);
            end
          end else begin
            null_pos = null_pos + 2'd1;
            got      = 1'b0;
          end
        end
        jns_pkg::PH_SIGN: got = start_number(ch, r);
        jns_pkg::PH_ZEROS, jns_pkg::PH_INT: begin
          got = 1'b0;
          if (scan_ph == jns_pkg::PH_ZEROS && ch == CH_ZERO) begin
          end else if (is_dig(ch)) begin
            add_mant_digit(ch);
            scan_ph = jns_pkg::PH_INT;
          end else if (ch == CH_DOT) begin
            dot_flag = 1'b1;
            scan_ph  = jns_pkg::PH_FRAC;
          end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
            scan_ph = jns_pkg::PH_EXP_START;
          end else begin
            r   = number_token(ch, 1'b0);
            got = 1'b1;
          end
        end
        jns_pkg::PH_FRAC: begin
          got = 1'b0;
          if (is_dig(ch)) begin
            add_mant_digit(ch);
            frac_cnt = frac_cnt + 8'd1;
          end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
            scan_ph = jns_pkg::PH_EXP_START;
          end else begin
            r   = number_token(ch, 1'b0);
            got = 1'b1;
          end
        end
        jns_pkg::PH_EXP_START: begin
          got = 1'b0;
          if (ch == CH_PLUS) begin
            scan_ph = jns_pkg::PH_EXP_SIGN;
          end else if (ch == CH_MINUS) begin
            exp_neg = 1'b1;
            scan_ph = jns_pkg::PH_EXP_SIGN;
          end else if (is_dig(ch)) begin
            add_exp_digit(ch);
          end else begin
            r   = number_token(ch, 1'b0);
            got = 1'b1;
          end
        end
        jns_pkg::PH_EXP_SIGN, jns_pkg::PH_EXP_DIG: begin
          if (is_dig(ch)) begin
            add_exp_digit(ch);
            got = 1'b0;
          end else begin
            r = number_token(ch, 1'b0);
          end
        end
        default: begin
          scan_clear();
          got = 1'b0;
        end
      endcase
    end
    return got;
  endfunction

  // Drive one input transaction; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [7:0] ch, input logic eom, input bit typed,
                           input jns_pkg::res_t want);
    jns_pkg::res_t r;
    bit            got;
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    got = scan_char(ch, eom, r);
    if (typed) expected_tokens.push_back(want);
    else if (got) expected_tokens.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic void add_char(input logic [7:0] ch, input logic eom = 1'b0);
    stim_t s;
    s.ch  = ch;
    s.eom = eom;
    token_chars.push_back(s);
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] ws_byte();
    return $urandom_range(1) ? 8'($urandom_range(32)) : (8'h80 | 8'($urandom_range(127)));
  endfunction

  // Something that ends a number: punctuation, any byte, or the end mark
  function automatic void add_terminator();
    case ($urandom_range(5))
      0: add_char(CH_COMMA);
      1: add_char("]");
      2: add_char("}");
      3: add_char(ws_byte());
      4: add_char(any_byte());
      default: add_char(any_byte(), 1'b1);
    endcase
  endfunction

  // Build one random token (mostly well-formed numbers) and send its characters
  task automatic build_token(input bit long_frac);
    int pick;
    int n;
    int bad_at;
    pick = long_frac ? 0 : $urandom_range(99);
    if (pick < 70) begin
      repeat ($urandom_range(2)) add_char(ws_byte());
      if ($urandom_range(1)) add_char(CH_MINUS);
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) add_char(CH_ZERO);
      n = ($urandom_range(9) == 0) ? $urandom_range(18, 25) : $urandom_range(1, 6);
      repeat (n) add_char(digit_byte());
      if (long_frac || $urandom_range(9) < 4) begin
        add_char(CH_DOT);
        n = long_frac ? $urandom_range(130, 270) : $urandom_range(0, 6);
        repeat (n) add_char(digit_byte());
      end
      if ($urandom_range(9) < 4) begin
        add_char($urandom_range(1) ? CH_LOW_E : CH_UP_E);
        case ($urandom_range(2))
          1: add_char(CH_PLUS);
          2: add_char(CH_MINUS);
          default: ;
        endcase
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
        repeat (n) add_char(digit_byte());
      end
      add_terminator();
    end else if (pick < 80) begin
      // null literal, sometimes with one tail character corrupted
      bad_at = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      add_char(CH_N);
      add_char(bad_at == 1 ? any_byte() : CH_U);
      add_char(bad_at == 2 ? any_byte() : CH_L);
      add_char(bad_at == 3 ? any_byte() : CH_L);
    end else if (pick < 90) begin
      // broken sequences
      case ($urandom_range(3))
        0: begin
          add_char(CH_MINUS);
          if ($urandom_range(1)) add_char(any_byte());
          else add_char(any_byte(), 1'b1);
        end
        1: begin
          add_char(digit_byte());
          add_char($urandom_range(1) ? CH_LOW_E : CH_UP_E);
          if ($urandom_range(1)) add_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
          add_char(any_byte(), 1'b1);
        end
        2: begin
          add_char(digit_byte());
          add_char(CH_DOT);
          add_char(any_byte());
        end
        default: begin
          add_char(CH_N);
          repeat ($urandom_range(2)) add_char(any_byte());
          add_char(any_byte(), 1'b1);
        end
      endcase
    end else begin
      // noise
      repeat ($urandom_range(1, 4)) add_char(any_byte());
      if ($urandom_range(4) == 0) add_char(any_byte(), 1'b1);
    end
    while (token_chars.size() != 0) begin
      stim_t s;
      s = token_chars.pop_front();
      send_item(s.ch, s.eom, 1'b0, NO_RES);
    end
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_tready <= (sink_idle == 0) || ($urandom_range(99) >= sink_idle);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      seen_tok.kind              = jns_pkg::kind_e'(m_axis_tuser);
      seen_tok.is_negative       = m_axis_tdata[0];
      seen_tok.mantissa          = m_axis_tdata[64:1];
      seen_tok.decimal_exponent  = m_axis_tdata[96:65];
      seen_tok.error_code        = jns_pkg::err_e'(m_axis_tdata[98:97]);
      seen_tok.terminator        = m_axis_tdata[106:99];
      seen_tok.ended_by_end_mark = m_axis_tdata[107];
      if (expected_tokens.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result transaction with no token pending: tuser %h tdata %h",
                   $realtime, m_axis_tuser, m_axis_tdata);
      end else begin
        want_tok = expected_tokens.pop_front();
        if (seen_tok.kind !== want_tok.kind ||
            seen_tok.is_negative !== want_tok.is_negative ||
            seen_tok.mantissa !== want_tok.mantissa ||
            seen_tok.decimal_exponent !== want_tok.decimal_exponent ||
            seen_tok.error_code !== want_tok.error_code ||
            seen_tok.terminator !== want_tok.terminator ||
            seen_tok.ended_by_end_mark !== want_tok.ended_by_end_mark) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $write("%0t: token mismatch (exp/act) kind %0d/%0d neg %b/%b mant %h/%h ",
                   $realtime, want_tok.kind, seen_tok.kind, want_tok.is_negative,
                   seen_tok.is_negative, want_tok.mantissa, seen_tok.mantissa);
            $display("dexp %h/%h err %0d/%0d term %h/%h eom %b/%b",
                     want_tok.decimal_exponent, seen_tok.decimal_exponent,
                     want_tok.error_code, seen_tok.error_code, want_tok.terminator,
                     seen_tok.terminator, want_tok.ended_by_end_mark,
                     seen_tok.ended_by_end_mark);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("json_number_scanner_unit verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int stage;
    items_sent   = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    src_idle     = 0;
    sink_idle    = 0;
    scan_clear();

    // Directed rows: whitespace extremes, end in whitespace, null, bad null,
    // double minus, a full float, end after exponent mark, end inside null
    dir_rows = '{
      '{8'h00,    1'b0, 1'b0, NO_RES},
      '{8'hFF,    1'b0, 1'b0, NO_RES},
      '{8'hAA,    1'b1, 1'b1,
        fixed_res(jns_pkg::KIND_UNSIGNED, jns_pkg::ERR_END, 8'h00, 1'b1)},
      '{CH_N,     1'b0, 1'b0, NO_RES},
      '{CH_U,     1'b0, 1'b0, NO_RES},
      '{CH_L,     1'b0, 1'b0, NO_RES},
      '{CH_L,     1'b0, 1'b1,
        fixed_res(jns_pkg::KIND_NULL, jns_pkg::ERR_OK, 8'h00, 1'b0)},
      '{CH_N,     1'b0, 1'b0, NO_RES},
      '{CH_X,     1'b0, 1'b0, NO_RES},
      '{CH_L,     1'b0, 1'b0, NO_RES},
      '{CH_L,     1'b0, 1'b1,
        fixed_res(jns_pkg::KIND_UNSIGNED, jns_pkg::ERR_NULL, 8'h00, 1'b0)},
      '{CH_MINUS, 1'b0, 1'b0, NO_RES},
      '{CH_MINUS, 1'b0, 1'b1,
        fixed_res(jns_pkg::KIND_UNSIGNED, jns_pkg::ERR_NO_DIGIT, CH_MINUS, 1'b0)},
      '{CH_MINUS, 1'b0, 1'b0, NO_RES},
      '{CH_ZERO,  1'b0, 1'b0, NO_RES},
      '{"7",      1'b0, 1'b0, NO_RES},
      '{CH_DOT,   1'b0, 1'b0, NO_RES},
      '{"5",      1'b0, 1'b0, NO_RES},
      '{CH_LOW_E, 1'b0, 1'b0, NO_RES},
      '{CH_PLUS,  1'b0, 1'b0, NO_RES},
      '{CH_NINE,  1'b0, 1'b0, NO_RES},
      '{CH_COMMA, 1'b0, 1'b0, NO_RES},
      '{"1",      1'b0, 1'b0, NO_RES},
      '{CH_UP_E,  1'b0, 1'b0, NO_RES},
      '{8'h00,    1'b1, 1'b1,
        fixed_res(jns_pkg::KIND_UNSIGNED, jns_pkg::ERR_END, 8'h00, 1'b1)},
      '{CH_N,     1'b0, 1'b0, NO_RES},
      '{8'h55,    1'b1, 1'b1,
        fixed_res(jns_pkg::KIND_UNSIGNED, jns_pkg::ERR_END, 8'h00, 1'b1)}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Three stages of flow control: both sides idle, swapped, then none
    for (stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          src_idle  = 22;
          sink_idle = 61;
        end
        1: begin
          src_idle  = 61;
          sink_idle = 22;
        end
        default: begin
          src_idle  = 0;
          sink_idle = 0;
        end
      endcase
      if (stage == 0) begin
        foreach (dir_rows[i])
          send_item(dir_rows[i].ch, dir_rows[i].eom, dir_rows[i].typed, dir_rows[i].want);
        // one number whose fraction count wraps past the signed byte range
        build_token(1'b1);
      end
      while (items_sent < (stage + 1) * ITEMS_PER_STAGE) build_token(1'b0);
    end
    s_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("json_number_scanner_unit verification clean");
    else
      $display("json_number_scanner_unit verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/jns_pkg.sv
design/jns_front.sv
design/jns_fifo.sv
design/jns_back.sv
design/json_number_scanner_unit.sv
test/json_number_scanner_unit_test.sv
